@@ sv/camera_primary_ray_direction_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the primary ray direction block.
// Each macro fires an $error when the consequent fails.
// ----------------------------------------------------------------------------
`ifndef CAMERA_PRIMARY_RAY_DIRECTION_TOP_ASSERT_SVH
`define CAMERA_PRIMARY_RAY_DIRECTION_TOP_ASSERT_SVH

// Same-cycle implication.
`define CPRD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cprd assertion failed");

// Next-cycle implication.
`define CPRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cprd assertion failed");

`endif

@@ sv/cprd_pkg.sv @@
// ----------------------------------------------------------------------------
// cprd_pkg
// Shared widths, constants and types of the primary ray direction block.
// ----------------------------------------------------------------------------
`default_nettype none

package cprd_pkg;

   localparam int COORD_W    = 21;             // signed Q10.10 coordinate
   localparam int PACK_W     = 3 * COORD_W;    // packed x, y, z
   localparam int DIM_W      = 13;
   localparam logic [DIM_W-1:0] DIM_MAX = 13'd4096;
   localparam int PIX_W      = 12;
   localparam int DIR_W      = 16;
   localparam int MAG_W      = 51;             // magnitude of scaled direction
   localparam int NMAG_W     = 30;             // magnitude after normalizing
   localparam int SH_W       = 5;
   localparam int SOS_W      = 62;             // sum of three squares
   localparam int ROOT_W     = 32;
   localparam int SQ_STEPS   = 32;             // one root bit per stage
   localparam int QUO_W      = 15;
   localparam int DIV_STEPS  = QUO_W;          // one quotient bit per stage
   localparam int NUM_W      = 46;
   localparam int DEN_W      = ROOT_W + 1;
   localparam int PRE_STAGES = 8;
   localparam int ALL_STAGES = PRE_STAGES + SQ_STEPS + DIV_STEPS;

   typedef enum logic [2:0] {
      CSR_EYE    = 3'd0,
      CSR_TL     = 3'd1,
      CSR_TR     = 3'd2,
      CSR_BL     = 3'd3,
      CSR_WIDTH  = 3'd4,
      CSR_HEIGHT = 3'd5
   } csr_index_type;

   // Per-item data that rides alongside the square root.
   typedef struct packed {
      logic [2:0][NMAG_W-1:0] mag;
      logic [2:0]             neg;
      logic                   degen;
   } side_type;

   // Per-item data that rides alongside the dividers.
   typedef struct packed {
      logic [2:0] neg;
      logic       degen;
   } sign_type;

endpackage

`default_nettype wire

@@ sv/camera_primary_ray_direction_top.sv @@
// ----------------------------------------------------------------------------
// camera_primary_ray_direction_top
// Pinhole camera primary ray generation: pixel in, unit ray direction out.
// ----------------------------------------------------------------------------
// The block accepts one pixel word per cycle while req_ready is high (the
// pipeline stalls while the skid entry is full) and returns one direction
// word per pixel, in order. The first of the 55 pipeline stages is loaded at
// the accepting edge; the output register is loaded from the last stage and
// drives the rsp_ ports. The pipeline holds eight stages that build the
// scaled direction, normalize it and sum its squares, 32 stages of the square
// root (one root bit each) and 15 stages of the three dividers (one quotient
// bit each). All stages advance together; a two-entry output buffer lets a
// new pixel enter while a finished result waits for rsp_ready.
// Configuration is written through the csr_ port, which is always ready; it
// must be written only while no pixel is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module camera_primary_ray_direction_top import cprd_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic        [PIX_W-1:0]  req_pixel_column,
   input  wire logic        [PIX_W-1:0]  req_pixel_row,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed      [DIR_W-1:0]  rsp_dir_x,
   output logic signed      [DIR_W-1:0]  rsp_dir_y,
   output logic signed      [DIR_W-1:0]  rsp_dir_z,
   output logic                          rsp_degenerate,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic        [2:0]        csr_index,
   input  wire logic        [PACK_W-1:0] csr_wdata
);

   // Configuration registers.
   logic [PACK_W-1:0] eye_ff, tl_ff, tr_ff, bl_ff;
   logic [DIM_W-1:0]  width_ff, height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eye_ff    <= '0;
         tl_ff     <= '0;
         tr_ff     <= '0;
         bl_ff     <= '0;
         width_ff  <= 13'd640;
         height_ff <= 13'd480;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_EYE:    eye_ff    <= csr_wdata;
            CSR_TL:     tl_ff     <= csr_wdata;
            CSR_TR:     tr_ff     <= csr_wdata;
            CSR_BL:     bl_ff     <= csr_wdata;
            CSR_WIDTH:  width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_HEIGHT: height_ff <= csr_wdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // The whole pipeline moves only while the skid entry is empty.
   logic en;
   logic skid_v_ff;
   assign en        = !skid_v_ff;
   assign req_ready = en;

   logic v_ff [ALL_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ALL_STAGES; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else if (en) begin
         v_ff[0] <= req_valid;
         for (int i = 1; i < ALL_STAGES; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   // Stage 1: edge vectors, corner minus eye, and the pixel scale products.
   // Scaling everything by 2*W*H keeps the pixel center exact in integers.
   logic signed [COORD_W:0] tle_in [3], ex_in [3], ey_in [3];
   logic signed [COORD_W:0] tle_ff [3], ex_ff [3], ey_ff [3];
   logic [DIM_W-1:0]        w_cl, h_cl;
   logic [DIM_W-1:0]        col2, row2;
   logic [24:0]             wh_ff, ch_ff, rw_ff;
   logic                    deg1_in, deg1_ff;
   logic                    ezx, ezy;

   always_comb begin
      w_cl = (width_ff  > DIM_MAX) ? DIM_MAX : width_ff;
      h_cl = (height_ff > DIM_MAX) ? DIM_MAX : height_ff;
      col2 = {req_pixel_column, 1'b1};
      row2 = {req_pixel_row, 1'b1};
      ezx  = 1'b1;
      ezy  = 1'b1;
      for (int k = 0; k < 3; k++) begin
         tle_in[k] = (COORD_W+1)'($signed(tl_ff[k*COORD_W +: COORD_W]))
                   - (COORD_W+1)'($signed(eye_ff[k*COORD_W +: COORD_W]));
         ex_in[k]  = (COORD_W+1)'($signed(tr_ff[k*COORD_W +: COORD_W]))
                   - (COORD_W+1)'($signed(tl_ff[k*COORD_W +: COORD_W]));
         ey_in[k]  = (COORD_W+1)'($signed(bl_ff[k*COORD_W +: COORD_W]))
                   - (COORD_W+1)'($signed(tl_ff[k*COORD_W +: COORD_W]));
         if (ex_in[k] != '0) ezx = 1'b0;
         if (ey_in[k] != '0) ezy = 1'b0;
      end
      deg1_in = (w_cl == '0) || (h_cl == '0) || ezx || ezy;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            tle_ff[k] <= tle_in[k];
            ex_ff[k]  <= ex_in[k];
            ey_ff[k]  <= ey_in[k];
         end
         wh_ff   <= 25'(w_cl * h_cl);
         ch_ff   <= 25'(col2 * h_cl);
         rw_ff   <= 25'(row2 * w_cl);
         deg1_ff <= deg1_in;
      end
   end

   // Stage 2: the nine products of the three components.
   logic signed [48:0] pa_ff [3], pb_ff [3], pc_ff [3];
   logic signed [26:0] wh2_s, ch_s, rw_s;
   logic               deg2_ff;

   assign wh2_s = $signed({1'b0, wh_ff, 1'b0});
   assign ch_s  = $signed({2'b0, ch_ff});
   assign rw_s  = $signed({2'b0, rw_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            pa_ff[k] <= tle_ff[k] * wh2_s;
            pb_ff[k] <= ex_ff[k]  * ch_s;
            pc_ff[k] <= ey_ff[k]  * rw_s;
         end
         deg2_ff <= deg1_ff;
      end
   end

   // Stage 3: the scaled direction.
   logic signed [MAG_W:0] d_ff [3];
   logic                  deg3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            d_ff[k] <= (MAG_W+1)'(pa_ff[k]) + (MAG_W+1)'(pb_ff[k])
                     + (MAG_W+1)'(pc_ff[k]);
         end
         deg3_ff <= deg2_ff;
      end
   end

   // Stage 4: sign and magnitude.
   logic [MAG_W-1:0] mag4_ff [3];
   logic [2:0]       neg4_ff;
   logic             deg4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            neg4_ff[k] <= d_ff[k][MAG_W];
            mag4_ff[k] <= d_ff[k][MAG_W] ? MAG_W'(-d_ff[k]) : MAG_W'(d_ff[k]);
         end
         deg4_ff <= deg3_ff;
      end
   end

   // Stage 5: shift that brings the largest magnitude below 2^30. The OR of
   // the three has the same top bit as the largest one.
   logic [MAG_W-1:0] mor;
   logic [SH_W-1:0]  sh_in, sh_ff;
   logic [MAG_W-1:0] mag5_ff [3];
   logic [2:0]       neg5_ff;
   logic             deg5_ff;

   always_comb begin
      mor   = mag4_ff[0] | mag4_ff[1] | mag4_ff[2];
      sh_in = '0;
      for (int i = NMAG_W; i < MAG_W; i++) begin
         if (mor[i]) sh_in = SH_W'(i - NMAG_W + 1);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sh_ff   <= sh_in;
         mag5_ff <= mag4_ff;
         neg5_ff <= neg4_ff;
         deg5_ff <= deg4_ff || (mor == '0);
      end
   end

   // Stage 6: normalized magnitudes. Stage 7: squares. Stage 8: their sum.
   side_type          side6_ff, side7_ff, side8_ff;
   logic [2*NMAG_W-1:0] sq_ff [3];
   logic [SOS_W-1:0]  sos_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            side6_ff.mag[k] <= NMAG_W'(mag5_ff[k] >> sh_ff);
            sq_ff[k]        <= side6_ff.mag[k] * side6_ff.mag[k];
         end
         side6_ff.neg   <= neg5_ff;
         side6_ff.degen <= deg5_ff;
         side7_ff       <= side6_ff;
         side8_ff       <= side7_ff;
         sos_ff <= SOS_W'(sq_ff[0]) + SOS_W'(sq_ff[1]) + SOS_W'(sq_ff[2]);
      end
   end

   // Length of the normalized vector; the side data waits alongside.
   logic [ROOT_W-1:0] len;
   side_type          sdl_ff [SQ_STEPS];

   cprd_isqrt u_isqrt (
      .clock (clock),
      .en    (en),
      .rad   (sos_ff),
      .root  (len)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         sdl_ff[0] <= side8_ff;
         for (int i = 1; i < SQ_STEPS; i++) begin
            sdl_ff[i] <= sdl_ff[i-1];
         end
      end
   end

   // Each component is round(mag * 16384 / len), done as
   // (mag * 32768 + len) / (2 * len).
   side_type         sq_out;
   logic [DEN_W-1:0] den;
   logic [QUO_W-1:0] quo [3];
   sign_type         sgn_in;
   sign_type         sgn_ff [DIV_STEPS];

   assign sq_out       = sdl_ff[SQ_STEPS-1];
   assign den          = {len, 1'b0};
   assign sgn_in.neg   = sq_out.neg;
   assign sgn_in.degen = sq_out.degen || (len == '0);

   for (genvar k = 0; k < 3; k++) begin : g_lane
      logic [NUM_W-1:0] num;
      assign num = NUM_W'({sq_out.mag[k], 15'd0}) + NUM_W'(len);

      cprd_div u_div (
         .clock (clock),
         .en    (en),
         .num   (num),
         .den   (den),
         .quo   (quo[k])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sgn_ff[0] <= sgn_in;
         for (int i = 1; i < DIV_STEPS; i++) begin
            sgn_ff[i] <= sgn_ff[i-1];
         end
      end
   end

   // Signed result of the last stage; a degenerate item gives zeros.
   logic [DIR_W-1:0] res_dir [3];
   logic             res_deg;
   sign_type         sgn_out;

   assign sgn_out = sgn_ff[DIV_STEPS-1];
   assign res_deg = sgn_out.degen;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (sgn_out.degen) begin
            res_dir[k] = '0;
         end else if (sgn_out.neg[k]) begin
            res_dir[k] = DIR_W'(-{1'b0, quo[k]});
         end else begin
            res_dir[k] = DIR_W'(quo[k]);
         end
      end
   end

   // Output register with one skid entry behind it.
   logic             last_v;
   logic             out_v_ff;
   logic [DIR_W-1:0] out_dir_ff [3];
   logic             out_deg_ff;
   logic [DIR_W-1:0] skid_dir_ff [3];
   logic             skid_deg_ff;

   assign last_v = v_ff[ALL_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (rsp_ready) begin
            skid_v_ff <= 1'b0;
         end
      end else if (!out_v_ff || rsp_ready) begin
         out_v_ff <= last_v;
      end else if (last_v) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (rsp_ready) begin
            out_dir_ff <= skid_dir_ff;
            out_deg_ff <= skid_deg_ff;
         end
      end else if (!out_v_ff || rsp_ready) begin
         out_dir_ff <= res_dir;
         out_deg_ff <= res_deg;
      end else begin
         skid_dir_ff <= res_dir;
         skid_deg_ff <= res_deg;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_dir_x      = $signed(out_dir_ff[0]);
   assign rsp_dir_y      = $signed(out_dir_ff[1]);
   assign rsp_dir_z      = $signed(out_dir_ff[2]);
   assign rsp_degenerate = out_deg_ff;

endmodule

`default_nettype wire

@@ sv/cprd_isqrt.sv @@
// ----------------------------------------------------------------------------
// cprd_isqrt
// Pipelined integer square root, one result bit resolved per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cprd_isqrt import cprd_pkg::*; (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic [SOS_W-1:0]  rad,
   output logic      [ROOT_W-1:0] root
);

   logic [63:0] num_ff [SQ_STEPS];
   logic [63:0] res_ff [SQ_STEPS];

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
      localparam logic [63:0] PW = 64'd1 << (2 * (SQ_STEPS - 1 - k));
      logic [63:0] num_cur;
      logic [63:0] res_cur;
      logic [63:0] trial;
      logic [63:0] num_in;
      logic [63:0] res_in;

      if (k == 0) begin : g_first
         assign num_cur = 64'(rad);
         assign res_cur = '0;
      end else begin : g_next
         assign num_cur = num_ff[k-1];
         assign res_cur = res_ff[k-1];
      end

      always_comb begin
         trial = res_cur + PW;
         if (num_cur >= trial) begin
            num_in = num_cur - trial;
            res_in = (res_cur >> 1) + PW;
         end else begin
            num_in = num_cur;
            res_in = res_cur >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[k] <= num_in;
            res_ff[k] <= res_in;
         end
      end
   end

   assign root = res_ff[SQ_STEPS-1][ROOT_W-1:0];

endmodule

`default_nettype wire

@@ sv/cprd_div.sv @@
// ----------------------------------------------------------------------------
// cprd_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cprd_div import cprd_pkg::*; (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic      [QUO_W-1:0] quo
);

   localparam int REM_W = NUM_W + 2;

   logic [REM_W-1:0] rem_ff [DIV_STEPS];
   logic [DEN_W-1:0] den_ff [DIV_STEPS];
   logic [QUO_W-1:0] quo_ff [DIV_STEPS];

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      localparam int SH = DIV_STEPS - 1 - k;
      logic [REM_W-1:0] rem_cur;
      logic [DEN_W-1:0] den_cur;
      logic [QUO_W-1:0] quo_cur;
      logic [REM_W-1:0] sub;
      logic [REM_W-1:0] rem_in;
      logic [QUO_W-1:0] quo_in;

      if (k == 0) begin : g_first
         assign rem_cur = REM_W'(num);
         assign den_cur = den;
         assign quo_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[k-1];
         assign den_cur = den_ff[k-1];
         assign quo_cur = quo_ff[k-1];
      end

      always_comb begin
         sub    = REM_W'(den_cur) << SH;
         quo_in = quo_cur;
         if (rem_cur >= sub) begin
            rem_in     = rem_cur - sub;
            quo_in[SH] = 1'b1;
         end else begin
            rem_in = rem_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_cur;
            quo_ff[k] <= quo_in;
         end
      end
   end

   assign quo = quo_ff[DIV_STEPS-1];

endmodule

`default_nettype wire

@@ sv/cprd_checker.sv @@
// ----------------------------------------------------------------------------
// cprd_checker
// Port-level checks of the primary ray direction block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "camera_primary_ray_direction_top_assert.svh"

module cprd_checker import cprd_pkg::*; (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic signed [DIR_W-1:0] rsp_dir_x,
   input wire logic signed [DIR_W-1:0] rsp_dir_y,
   input wire logic signed [DIR_W-1:0] rsp_dir_z,
   input wire logic                    rsp_degenerate
);

   // A stalled result stays offered.
   `CPRD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // A stalled result keeps its direction.
   `CPRD_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_dir_x) && $stable(rsp_dir_y) && $stable(rsp_dir_z))

   // A degenerate ray carries a zero direction.
   `CPRD_ASSERT_NOW(a_degen_zero, clock, reset, rsp_valid && rsp_degenerate, rsp_dir_x == 16'sd0 && rsp_dir_y == 16'sd0 && rsp_dir_z == 16'sd0)

   // A unit direction stays within +/-1.0 (+/-16384) in Q1.14.
   `CPRD_ASSERT_NOW(a_dir_range, clock, reset, rsp_valid, rsp_dir_x <= 16'sd16384 && rsp_dir_x >= -16'sd16384 && rsp_dir_y <= 16'sd16384 && rsp_dir_y >= -16'sd16384 && rsp_dir_z <= 16'sd16384 && rsp_dir_z >= -16'sd16384)

endmodule

bind camera_primary_ray_direction_top cprd_checker u_cprd_checker (.*);

`default_nettype wire

@@ bench/tb_camera_primary_ray_direction_top.sv @@
// ----------------------------------------------------------------------------
// tb_camera_primary_ray_direction_top
// Self-checking bench for the pinhole camera primary ray direction block.
// ----------------------------------------------------------------------------
// Pixel words are offered on the req_ channel and every accepted pixel gets a
// predicted unit direction, computed here in 64-bit integer arithmetic from a
// private copy of the camera registers. The response monitor compares each
// returned word with the oldest prediction. Test tasks cover the corner
// cases, several camera settings under different idle and stall patterns, and
// a long response stall that backs the pipeline up into the input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_camera_primary_ray_direction_top;
   import cprd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int  DRAIN_CYCLES = 80;
   localparam real RUN_LIMIT_NS = 2.0e6;
   localparam int  Q_ONE        = 21'sd1024;

   // A predicted or observed direction word.
   typedef struct {
      logic signed [DIR_W-1:0] x;
      logic signed [DIR_W-1:0] y;
      logic signed [DIR_W-1:0] z;
      logic                    degen;
   } ray_dir_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic             req_valid        = 1'b0;
   logic             req_ready;
   logic [PIX_W-1:0] req_pixel_column = '0;
   logic [PIX_W-1:0] req_pixel_row    = '0;

   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [DIR_W-1:0] rsp_dir_x;
   logic signed [DIR_W-1:0] rsp_dir_y;
   logic signed [DIR_W-1:0] rsp_dir_z;
   logic                    rsp_degenerate;

   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [2:0]        csr_index = CSR_EYE;
   logic [PACK_W-1:0] csr_wdata = '0;

   // Private copy of the camera registers, as they stand after reset.
   logic [PACK_W-1:0] cam_eye    = '0;
   logic [PACK_W-1:0] cam_tl     = '0;
   logic [PACK_W-1:0] cam_tr     = '0;
   logic [PACK_W-1:0] cam_bl     = '0;
   logic [DIM_W-1:0]  cam_width  = 13'd640;
   logic [DIM_W-1:0]  cam_height = 13'd480;

   // Directions still owed by the block, oldest first.
   ray_dir_type pending_dirs[$];

   int error_count   = 0;
   int send_idle_pct = 0;     // chance in a hundred that the sender idles
   int sink_stall_pct = 0;    // chance in a hundred that the receiver stalls
   int sink_hold_req = 0;     // asks the receiver for a long hold-off

   always #5 clock = ~clock;

   camera_primary_ray_direction_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_column (req_pixel_column),
      .req_pixel_row    (req_pixel_row),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_dir_x        (rsp_dir_x),
      .rsp_dir_y        (rsp_dir_y),
      .rsp_dir_z        (rsp_dir_z),
      .rsp_degenerate   (rsp_degenerate),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // Direction predictor.
   // ------------------------------------------------------------------------

   // Signed Q10.10 coordinate k (0 = x, 1 = y, 2 = z) of a packed point.
   function automatic longint coord(logic [PACK_W-1:0] p, int k);
      logic signed [COORD_W-1:0] c;
      c = p[k*COORD_W +: COORD_W];
      return longint'(c);
   endfunction

   function automatic logic [PACK_W-1:0] pack_point(longint x, longint y, longint z);
      logic [COORD_W-1:0] cx, cy, cz;
      cx = x[COORD_W-1:0];
      cy = y[COORD_W-1:0];
      cz = z[COORD_W-1:0];
      return {cz, cy, cx};
   endfunction

   // Floor of the square root, one result bit per pass.
   function automatic longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n    = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // The direction from the eye through the center of pixel (col, row).
   // The vector is formed exactly, scaled by 2*W*H, so no fractions appear.
   function automatic ray_dir_type predict_ray(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
      ray_dir_type       r;
      longint            w, h, tl, ex, ey;
      longint            d[3];
      longint unsigned   mag[3];
      logic              neg[3];
      longint unsigned   max_mag, sum_sq, len, q;
      logic [DIR_W-1:0]  v;
      bit                edge_x_zero, edge_y_zero;
      int                sh;
      r = '{x: '0, y: '0, z: '0, degen: 1'b1};
      // Widths and heights past the largest image size saturate.
      w = (cam_width  > DIM_MAX) ? longint'(DIM_MAX) : longint'(cam_width);
      h = (cam_height > DIM_MAX) ? longint'(DIM_MAX) : longint'(cam_height);
      if (w == 0 || h == 0) return r;
      edge_x_zero = 1;
      edge_y_zero = 1;
      max_mag = 0;
      for (int k = 0; k < 3; k++) begin
         tl = coord(cam_tl, k);
         ex = coord(cam_tr, k) - tl;
         ey = coord(cam_bl, k) - tl;
         if (ex != 0) edge_x_zero = 0;
         if (ey != 0) edge_y_zero = 0;
         d[k] = (tl - coord(cam_eye, k)) * (2 * w * h)
              + ex * ((2 * longint'(col) + 1) * h)
              + ey * ((2 * longint'(row) + 1) * w);
         neg[k] = d[k] < 0;
         mag[k] = neg[k] ? longint'(-d[k]) : longint'(d[k]);
         if (mag[k] > max_mag) max_mag = mag[k];
      end
      if (edge_x_zero || edge_y_zero || max_mag == 0) return r;
      // Bring the largest magnitude below 2^30 before squaring.
      sh = 0;
      while ((max_mag >> sh) >= (64'd1 << 30)) sh++;
      sum_sq = 0;
      for (int k = 0; k < 3; k++) begin
         mag[k] = mag[k] >> sh;
         sum_sq = sum_sq + mag[k] * mag[k];
      end
      len = floor_sqrt(sum_sq);
      if (len == 0) return r;
      for (int k = 0; k < 3; k++) begin
         // Round half up of mag * 16384 / len.
         q = (mag[k] * 64'd32768 + len) / (2 * len);
         v = q[DIR_W-1:0];
         if (neg[k]) v = -v;
         if (k == 0) r.x = v;
         else if (k == 1) r.y = v;
         else r.z = v;
      end
      r.degen = 1'b0;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Response monitor and receiver. Outputs are sampled at the rising edge,
   // before the block's own updates land, and rsp_ready is changed right
   // after. A hold-off request parks rsp_ready low for the given cycles.
   // ------------------------------------------------------------------------
   int hold_left = 0;

   always @(posedge clock) begin
      ray_dir_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_dirs.size() == 0) begin
            $error("direction word with no pixel outstanding");
            error_count++;
         end else begin
            want = pending_dirs.pop_front();
            if (rsp_dir_x !== want.x) begin
               $error("dir_x expected %0d actual %0d", want.x, rsp_dir_x);
               error_count++;
            end
            if (rsp_dir_y !== want.y) begin
               $error("dir_y expected %0d actual %0d", want.y, rsp_dir_y);
               error_count++;
            end
            if (rsp_dir_z !== want.z) begin
               $error("dir_z expected %0d actual %0d", want.z, rsp_dir_z);
               error_count++;
            end
            if (rsp_degenerate !== want.degen) begin
               $error("degenerate expected %0d actual %0d", want.degen, rsp_degenerate);
               error_count++;
            end
         end
      end
      if (sink_hold_req > 0) begin
         hold_left     = sink_hold_req;
         sink_hold_req = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Shared drivers. Every task starts and ends just after a rising edge.
   // ------------------------------------------------------------------------

   // Offers one pixel word and records its predicted direction on acceptance.
   // Valid is left high so back-to-back words never lower and raise it in the
   // same step; it is lowered only when the sender idles or drains.
   task automatic send_pixel(int col, int row);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_pixel_column <= col[PIX_W-1:0];
      req_pixel_row    <= row[PIX_W-1:0];
      do @(posedge clock); while (!req_ready);
      pending_dirs.push_back(predict_ray(col[PIX_W-1:0], row[PIX_W-1:0]));
   endtask

   // Stops offering and waits until every predicted direction has returned,
   // then lets the pipeline settle before any register is touched.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_dirs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [PACK_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_EYE:    cam_eye    = data;
         CSR_TL:     cam_tl     = data;
         CSR_TR:     cam_tr     = data;
         CSR_BL:     cam_bl     = data;
         CSR_WIDTH:  cam_width  = data[DIM_W-1:0];
         CSR_HEIGHT: cam_height = data[DIM_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_camera(logic [PACK_W-1:0] eye, logic [PACK_W-1:0] tl,
                             logic [PACK_W-1:0] tr, logic [PACK_W-1:0] bl,
                             int w, int h);
      write_reg(CSR_EYE, eye);
      write_reg(CSR_TL, tl);
      write_reg(CSR_TR, tr);
      write_reg(CSR_BL, bl);
      write_reg(CSR_WIDTH, PACK_W'(w));
      write_reg(CSR_HEIGHT, PACK_W'(h));
   endtask

   // A plain camera: eye at the origin, a 2x2 image plane one unit ahead.
   task automatic set_basic_camera(int w, int h);
      set_camera(pack_point(0, 0, 0),
                 pack_point(-Q_ONE, Q_ONE, Q_ONE),
                 pack_point(Q_ONE, Q_ONE, Q_ONE),
                 pack_point(-Q_ONE, -Q_ONE, Q_ONE), w, h);
   endtask

   // ------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------

   // Pixels under the reset settings, where all corners sit at zero.
   task automatic test_reset_camera();
      send_pixel(0, 0);
      send_pixel(639, 479);
      wait_drained();
   endtask

   // Corner pixels, pixels past the image, and a large saturated size.
   task automatic test_corner_pixels();
      set_basic_camera(640, 480);
      send_pixel(0, 0);
      send_pixel(639, 0);
      send_pixel(0, 479);
      send_pixel(639, 479);
      send_pixel(320, 240);
      send_pixel(4095, 4095);    // far outside the image: extrapolated
      send_pixel(4095, 0);
      send_pixel(2730, 1365);    // alternating bit patterns
      send_pixel(1365, 2730);
      wait_drained();
      write_reg(CSR_WIDTH, PACK_W'(8191));    // saturates to the largest size
      write_reg(CSR_HEIGHT, PACK_W'(4096));
      send_pixel(0, 0);
      send_pixel(4095, 4095);
      send_pixel(2048, 17);
      wait_drained();
   endtask

   // Zero edges, a zero dimension, the eye on the pixel center, and
   // coordinates at the ends of their range.
   task automatic test_degenerate_cases();
      set_camera(pack_point(0, 0, 0), pack_point(-Q_ONE, Q_ONE, Q_ONE),
                 pack_point(-Q_ONE, Q_ONE, Q_ONE), pack_point(-Q_ONE, -Q_ONE, Q_ONE),
                 16, 16);                           // top edge of zero length
      send_pixel(3, 4);
      wait_drained();
      write_reg(CSR_TR, pack_point(Q_ONE, Q_ONE, Q_ONE));
      write_reg(CSR_BL, pack_point(-Q_ONE, Q_ONE, Q_ONE));   // left edge of zero length
      send_pixel(3, 4);
      wait_drained();
      set_basic_camera(0, 16);                      // zero width
      send_pixel(0, 0);
      wait_drained();
      write_reg(CSR_WIDTH, PACK_W'(16));
      write_reg(CSR_HEIGHT, PACK_W'(0));            // zero height
      send_pixel(0, 0);
      wait_drained();
      // One pixel whose center is (0, 0, 1): put the eye exactly there.
      set_basic_camera(1, 1);
      write_reg(CSR_EYE, pack_point(0, 0, Q_ONE));
      send_pixel(0, 0);
      send_pixel(1, 1);
      wait_drained();
      // Extreme coordinates in every axis.
      set_camera(pack_point(-(1 << 20), -(1 << 20), -(1 << 20)),
                 pack_point((1 << 20) - 1, (1 << 20) - 1, (1 << 20) - 1),
                 pack_point(-(1 << 20), (1 << 20) - 1, -(1 << 20)),
                 pack_point((1 << 20) - 1, -(1 << 20), -(1 << 20)), 4096, 4096);
      send_pixel(0, 0);
      send_pixel(4095, 4095);
      send_pixel(4095, 0);
      wait_drained();
   endtask

   // A random camera: any packed value, sizes mostly moderate, sometimes at
   // the extremes, now and then a collapsed edge.
   task automatic randomize_camera();
      int w, h, pick;
      logic [PACK_W-1:0] tl;
      pick = $urandom_range(9);
      w = (pick == 0) ? 1 : (pick == 1) ? 4096 : (pick == 2) ? 8191 : $urandom_range(1, 800);
      pick = $urandom_range(9);
      h = (pick == 0) ? 1 : (pick == 1) ? 4096 : (pick == 2) ? 0 : $urandom_range(1, 800);
      tl = PACK_W'({$urandom, $urandom});
      set_camera(PACK_W'({$urandom, $urandom}), tl,
                 ($urandom_range(15) == 0) ? tl : PACK_W'({$urandom, $urandom}),
                 PACK_W'({$urandom, $urandom}), w, h);
   endtask

   // Random pixels, mostly inside the image, under the given idle and stall patterns.
   task automatic test_random_pixels(int idle_pct, int stall_pct, int count);
      int w, h;
      send_idle_pct  = idle_pct;
      sink_stall_pct = stall_pct;
      randomize_camera();
      w = (cam_width  == 0) ? 1 : (cam_width  > DIM_MAX) ? 4096 : cam_width;
      h = (cam_height == 0) ? 1 : (cam_height > DIM_MAX) ? 4096 : cam_height;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) begin
            wait_drained();     // a second camera halfway through
            randomize_camera();
            w = (cam_width  == 0) ? 1 : (cam_width  > DIM_MAX) ? 4096 : cam_width;
            h = (cam_height == 0) ? 1 : (cam_height > DIM_MAX) ? 4096 : cam_height;
         end
         if ($urandom_range(9) < 8) send_pixel($urandom_range(w - 1), $urandom_range(h - 1));
         else send_pixel($urandom_range(4095), $urandom_range(4095));
      end
      wait_drained();
   endtask

   // The receiver holds off long enough for the pipeline and output buffer
   // to fill; the sender keeps offering and must see req_ready drop.
   task automatic test_backpressure();
      send_idle_pct  = 0;
      sink_stall_pct = 0;
      set_basic_camera(64, 48);
      sink_hold_req = 300;
      for (int i = 0; i < 100; i++) send_pixel($urandom_range(63), $urandom_range(47));
      wait_drained();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_camera();
      test_corner_pixels();
      test_degenerate_cases();
      test_random_pixels(0, 0, 150);
      test_random_pixels(71, 0, 130);
      test_random_pixels(0, 71, 130);
      test_random_pixels(27, 27, 140);
      test_backpressure();
      if (error_count == 0 && pending_dirs.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+sv
sv/cprd_pkg.sv
sv/cprd_isqrt.sv
sv/cprd_div.sv
sv/camera_primary_ray_direction_top.sv
sv/cprd_checker.sv
bench/tb_camera_primary_ray_direction_top.sv
